// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define LPF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that must also hold during reset
`define LPF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lpf_pkg.sv
// Types, constants and codes of the look-ahead path follower
`timescale 1ns / 1ps
package lpf_pkg;
	localparam int PATH_DEPTH = 1024;
	localparam int IDX_W      = $clog2(PATH_DEPTH);
	localparam int LEN_W      = $clog2(PATH_DEPTH + 1);
	localparam int CFG_W      = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int AD_W       = 33;
	localparam int SQ_W       = 2 * AD_W;
	localparam int D2_W       = SQ_W + 2;
	localparam int ROOT_W     = D2_W / 2;
	localparam int SPD_W      = ROOT_W + 1;
	localparam int NUM_W      = AD_W + SPD_W + 1;
	localparam int LO_W       = 18;

	localparam logic [CFG_W-1:0] LOOK_AHEAD_RST = 31'd65536;
	localparam logic [CFG_W-1:0] SPEED_BIAS_RST = 31'd6554;

	localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_BIAS = 1'd1;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	localparam logic [2:0] STS_ISSUED  = 3'd0;
	localparam logic [2:0] STS_ENDED   = 3'd1;
	localparam logic [2:0] STS_NO_PATH = 3'd2;
	localparam logic [2:0] STS_LOADED  = 3'd3;
	localparam logic [2:0] STS_FULL    = 3'd4;
	localparam logic [2:0] STS_CLEARED = 3'd5;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] ref_vel_x;
		logic signed [31:0] ref_vel_y;
		logic signed [31:0] ref_vel_z;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] cmd_vel_x;
		logic signed [31:0] cmd_vel_y;
		logic signed [31:0] cmd_vel_z;
		logic [9:0]         nearest_index;
		logic [10:0]        target_index;
	} out_item_t;

	// handshake of the iterative units
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;
endpackage

// File: hdl/lpf_path_mem.sv
// Path store: point positions and reference velocities, one write and one read port
`timescale 1ns / 1ps
module lpf_path_mem import lpf_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  vec3_t            wpos,
	input  vec3_t            wvel,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output vec3_t            rpos,
	output vec3_t            rvel
);
	vec3_t pos_mem [PATH_DEPTH];
	vec3_t vel_mem [PATH_DEPTH];
	vec3_t rpos_q;
	vec3_t rvel_q;

	always_ff @(posedge clk) begin
		if (we) begin
			pos_mem[waddr] <= wpos;
			vel_mem[waddr] <= wvel;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rpos_q <= pos_mem[raddr];
			rvel_q <= vel_mem[raddr];
		end
	end

	assign rpos = rpos_q;
	assign rvel = rvel_q;
endmodule

// File: hdl/lpf_dist.sv
// Pipelined squared distance between a stored point and a reference point
`timescale 1ns / 1ps
module lpf_dist import lpf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [IDX_W-1:0] in_idx,
	input  vec3_t            pt,
	input  vec3_t            rf,
	output logic             out_valid,
	output logic [IDX_W-1:0] out_idx,
	output logic [D2_W-1:0]  out_d2,
	output logic             busy
);
	logic             v_s1, v_s2, v_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [AD_W-1:0]  ax_s1, ay_s1, az_s1;
	logic [SQ_W-1:0]  qx_s2, qy_s2, qz_s2;
	logic [D2_W-1:0]  d2_s3;

	function automatic logic [AD_W-1:0] absdiff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [AD_W:0] df;
		df = {{2{a[31]}}, a} - {{2{b[31]}}, b};
		if (df[AD_W]) absdiff = AD_W'(-df);
		else absdiff = df[AD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		ax_s1  <= absdiff(pt.x, rf.x);
		ay_s1  <= absdiff(pt.y, rf.y);
		az_s1  <= absdiff(pt.z, rf.z);
		idx_s2 <= idx_s1;
		qx_s2  <= ax_s1 * ax_s1;
		qy_s2  <= ay_s1 * ay_s1;
		qz_s2  <= az_s1 * az_s1;
		idx_s3 <= idx_s2;
		d2_s3  <= D2_W'(qx_s2) + D2_W'(qy_s2) + D2_W'(qz_s2);
	end

	assign out_valid = v_s3;
	assign out_idx   = idx_s3;
	assign out_d2    = d2_s3;
	assign busy      = v_s1 | v_s2 | v_s3;
endmodule

// File: hdl/lpf_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
module lpf_sqrt import lpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [D2_W-1:0]   radicand,
	output unit_sts_t         sts,
	output logic [ROOT_W-1:0] root
);
	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 3;

	logic [D2_W-1:0]   rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [REM_W-1:0]  rem_sh, trial;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[D2_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;
endmodule

// File: hdl/lpf_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lpf_div import lpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [ROOT_W-1:0] den,
	output unit_sts_t         sts,
	output logic [NUM_W-1:0]  quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  q_q;
	logic [ROOT_W-1:0] rem_q, den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q, done_q;
	logic [ROOT_W:0]   rem_sh, rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, q_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out on top while quotient bits enter below
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = q_q;
endmodule

// File: hdl/lookahead_path_follower_unit.sv
// Top level of the look-ahead path follower: sequencer, registers and result stage
//
//  channel  | direction | handshake              | payload
//  in       | input     | in_valid / in_stall    | in_data (in_item_t)
//  out      | output    | out_valid / out_stall  | out_data (out_item_t)
//  cfg      | input     | cfg_we                 | cfg_index, cfg_wdata
//
// Load and clear go from the execute state straight to the finish state; a step is bounded by two
// passes over the path memory (one point a cycle), two 34-step square roots and
// three 69-step divisions. The result register lets the next item in while a
// result waits. Reset clears the path length; the path memory itself is not cleared.
`timescale 1ns / 1ps
module lookahead_path_follower_unit import lpf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);
	`include "assert_macros.svh"

	typedef enum logic [20:0] {
		ST_IDLE     = 21'h000001,
		ST_EXEC     = 21'h000002,
		ST_SCAN1    = 21'h000004,
		ST_DRAIN1   = 21'h000008,
		ST_RD_BEST  = 21'h000010,
		ST_LAT_BEST = 21'h000020,
		ST_SCAN2    = 21'h000040,
		ST_DRAIN2   = 21'h000080,
		ST_ISS_T    = 21'h000100,
		ST_WAIT_T   = 21'h000200,
		ST_ISS_V    = 21'h000400,
		ST_WAIT_V   = 21'h000800,
		ST_SQ_N     = 21'h001000,
		ST_SQ_NW    = 21'h002000,
		ST_SQ_S     = 21'h004000,
		ST_SQ_SW    = 21'h008000,
		ST_MUL1     = 21'h010000,
		ST_MUL2     = 21'h020000,
		ST_DIV      = 21'h040000,
		ST_DIVW     = 21'h080000,
		ST_FIN      = 21'h100000
	} state_t;

	state_t               state_q;
	in_item_t             in_q;
	out_item_t            out_q;
	logic                 out_valid_q;
	logic [LEN_W-1:0]     len_q, scan_i_q, tgt_q;
	logic [IDX_W-1:0]     last_q, start_q, best_q;
	logic [CFG_W-1:0]     la_q, bias_q;
	logic [D2_W-1:0]      bestd_q, dt_q, dv_q;
	logic [2*CFG_W-1:0]   l2_q;
	logic                 found_q;
	vec3_t                ref_q, tpos_q;
	logic                 iss_v_q, iss_vel_q;
	logic [IDX_W-1:0]     iss_idx_q;
	logic [ROOT_W-1:0]    n_q;
	logic [SPD_W-1:0]     s_q;
	logic [1:0]           ax_q;
	logic                 neg_q;
	logic [AD_W+LO_W-1:0] pplo_q;
	logic [AD_W+SPD_W-LO_W-1:0] pphi_q;
	logic [NUM_W-1:0]     num_q;
	logic signed [31:0]   cx_q, cy_q, cz_q;
	logic [2:0]           sts_q;

	// memory and unit hookup
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_raddr;
	vec3_t                rd_pos, rd_vel;
	logic                 d_valid, d_busy, pipe_busy;
	logic [IDX_W-1:0]     d_idx;
	logic [D2_W-1:0]      d_d2;
	unit_sts_t            sq_sts, dv_sts;
	logic [ROOT_W-1:0]    sq_root;
	logic [NUM_W-1:0]     dv_quo;
	logic [LEN_W-1:0]     start_idx;

	// per-axis operands
	logic signed [31:0]   ax_t, ax_p;
	logic signed [AD_W:0] ax_df;
	logic [AD_W-1:0]      ax_ad;
	logic [32:0]          sat_lim;
	logic [31:0]          sat_mag, sat_res;

	assign mem_we = (state_q == ST_EXEC) && (in_q.command == CMD_LOAD) &&
		(len_q < LEN_W'(PATH_DEPTH));

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = scan_i_q[IDX_W-1:0];
		case (state_q)
			ST_SCAN1, ST_SCAN2: mem_re = 1'b1;
			ST_RD_BEST, ST_ISS_V: begin
				mem_re    = 1'b1;
				mem_raddr = best_q;
			end
			ST_ISS_T: begin
				mem_re    = 1'b1;
				mem_raddr = tgt_q[IDX_W-1:0];
			end
			default: mem_re = 1'b0;
		endcase
	end

	lpf_path_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (len_q[IDX_W-1:0]),
		.wpos  ({in_q.pos_x, in_q.pos_y, in_q.pos_z}),
		.wvel  ({in_q.ref_vel_x, in_q.ref_vel_y, in_q.ref_vel_z}),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rpos  (rd_pos),
		.rvel  (rd_vel)
	);

	lpf_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (iss_v_q),
		.in_idx    (iss_idx_q),
		.pt        (iss_vel_q ? rd_vel : rd_pos),
		.rf        (iss_vel_q ? vec3_t'('0) : ref_q),
		.out_valid (d_valid),
		.out_idx   (d_idx),
		.out_d2    (d_d2),
		.busy      (d_busy)
	);

	assign pipe_busy = iss_v_q | d_busy;

	lpf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_SQ_N) || (state_q == ST_SQ_S)),
		.radicand ((state_q == ST_SQ_S) ? dv_q : dt_q),
		.sts      (sq_sts),
		.root     (sq_root)
	);

	lpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIV),
		.num    (num_q),
		.den    (n_q),
		.sts    (dv_sts),
		.quo    (dv_quo)
	);

	assign start_idx = ({{(LEN_W-IDX_W){1'b0}}, last_q} < len_q) ?
		{{(LEN_W-IDX_W){1'b0}}, last_q} : '0;

	always_comb begin
		case (ax_q)
			2'd0: begin
				ax_t = tpos_q.x;
				ax_p = in_q.pos_x;
			end
			2'd1: begin
				ax_t = tpos_q.y;
				ax_p = in_q.pos_y;
			end
			default: begin
				ax_t = tpos_q.z;
				ax_p = in_q.pos_z;
			end
		endcase
	end

	assign ax_df   = {ax_t[31], ax_t[31], ax_t} - {ax_p[31], ax_p[31], ax_p};
	assign ax_ad   = ax_df[AD_W] ? AD_W'(-ax_df) : ax_df[AD_W-1:0];
	assign sat_lim = neg_q ? 33'h080000000 : 33'h07fffffff;
	assign sat_mag = (dv_quo > NUM_W'(sat_lim)) ? sat_lim[31:0] : dv_quo[31:0];
	assign sat_res = neg_q ? (32'd0 - sat_mag) : sat_mag;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q   <= LOOK_AHEAD_RST;
			bias_q <= SPEED_BIAS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOOK_AHEAD: la_q <= cfg_wdata;
				REG_SPEED_BIAS: bias_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			iss_v_q     <= 1'b0;
			iss_vel_q   <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			iss_v_q   <= mem_re && (state_q != ST_RD_BEST);
			iss_vel_q <= (state_q == ST_ISS_V);
			if (state_q == ST_FIN && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (d_valid && (state_q == ST_SCAN2 || state_q == ST_DRAIN2) && !found_q &&
				(d_d2 > D2_W'(l2_q)))
				found_q <= 1'b1;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (in_q.command)
						CMD_LOAD: if (mem_we) len_q <= len_q + 1'b1;
						CMD_CLEAR: begin
							len_q  <= '0;
							last_q <= '0;
						end
						CMD_STEP: if (len_q != '0) state_q <= ST_SCAN1;
						default: ;
					endcase
				end
				ST_SCAN1: if (scan_i_q == len_q - 1'b1) state_q <= ST_DRAIN1;
				ST_DRAIN1: if (!pipe_busy) state_q <= ST_RD_BEST;
				ST_RD_BEST: state_q <= ST_LAT_BEST;
				ST_LAT_BEST: begin
					found_q <= 1'b0;
					state_q <= ST_SCAN2;
				end
				ST_SCAN2: if (scan_i_q == len_q - 1'b1) state_q <= ST_DRAIN2;
				ST_DRAIN2: begin
					if (!pipe_busy) begin
						if (found_q) begin
							last_q  <= best_q;
							state_q <= ST_ISS_T;
						end else begin
							len_q   <= '0;
							last_q  <= '0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_ISS_T: state_q <= ST_WAIT_T;
				ST_WAIT_T: if (d_valid) state_q <= ST_ISS_V;
				ST_ISS_V: state_q <= ST_WAIT_V;
				ST_WAIT_V: if (d_valid) state_q <= ST_SQ_N;
				ST_SQ_N: state_q <= ST_SQ_NW;
				ST_SQ_NW: if (sq_sts.done) state_q <= ST_SQ_S;
				ST_SQ_S: state_q <= ST_SQ_SW;
				ST_SQ_SW: begin
					if (sq_sts.done) state_q <= (n_q == '0) ? ST_FIN : ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: if (dv_sts.done) state_q <= (ax_q == 2'd2) ? ST_FIN : ST_MUL1;
				ST_FIN: begin
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		iss_idx_q <= mem_raddr;
		if (state_q == ST_IDLE && in_valid) in_q <= in_data;

		if (d_valid && (state_q == ST_SCAN1 || state_q == ST_DRAIN1) &&
			(d_idx == start_q || d_d2 < bestd_q)) begin
			best_q  <= d_idx;
			bestd_q <= d_d2;
		end
		if (d_valid && (state_q == ST_SCAN2 || state_q == ST_DRAIN2) && !found_q &&
			(d_d2 > D2_W'(l2_q)))
			tgt_q <= {{(LEN_W-IDX_W){1'b0}}, d_idx};

		case (state_q)
			ST_EXEC: begin
				cx_q <= '0;
				cy_q <= '0;
				cz_q <= '0;
				case (in_q.command)
					CMD_LOAD: sts_q <= mem_we ? STS_LOADED : STS_FULL;
					CMD_CLEAR: sts_q <= STS_CLEARED;
					CMD_STEP: sts_q <= (len_q == '0) ? STS_NO_PATH : STS_ISSUED;
					default: sts_q <= STS_NO_PATH;
				endcase
				start_q  <= start_idx[IDX_W-1:0];
				scan_i_q <= start_idx;
				ref_q    <= {in_q.pos_x, in_q.pos_y, in_q.pos_z};
				l2_q     <= la_q * la_q;
			end
			ST_SCAN1, ST_SCAN2: scan_i_q <= scan_i_q + 1'b1;
			ST_LAT_BEST: begin
				ref_q    <= rd_pos;
				scan_i_q <= {{(LEN_W-IDX_W){1'b0}}, best_q};
			end
			ST_DRAIN2: begin
				if (!pipe_busy && !found_q) begin
					sts_q <= STS_ENDED;
					tgt_q <= len_q;
				end
			end
			ST_ISS_T: ref_q <= {in_q.pos_x, in_q.pos_y, in_q.pos_z};
			ST_WAIT_T: begin
				if (d_valid) begin
					dt_q   <= d_d2;
					tpos_q <= rd_pos;
				end
			end
			ST_WAIT_V: if (d_valid) dv_q <= d_d2;
			ST_SQ_NW: if (sq_sts.done) n_q <= sq_root;
			ST_SQ_SW: begin
				if (sq_sts.done) s_q <= SPD_W'(sq_root) + SPD_W'(bias_q);
				ax_q <= 2'd0;
			end
			ST_MUL1: begin
				neg_q  <= ax_df[AD_W];
				pplo_q <= ax_ad * s_q[LO_W-1:0];
				pphi_q <= ax_ad * s_q[SPD_W-1:LO_W];
			end
			ST_MUL2: begin
				num_q <= NUM_W'({pphi_q, {LO_W{1'b0}}}) + NUM_W'(pplo_q) + NUM_W'(n_q >> 1);
			end
			ST_DIVW: begin
				if (dv_sts.done) begin
					case (ax_q)
						2'd0: cx_q <= sat_res;
						2'd1: cy_q <= sat_res;
						default: cz_q <= sat_res;
					endcase
					ax_q <= ax_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_q.status        <= sts_q;
					out_q.cmd_vel_x     <= (sts_q == STS_ISSUED) ? cx_q : '0;
					out_q.cmd_vel_y     <= (sts_q == STS_ISSUED) ? cy_q : '0;
					out_q.cmd_vel_z     <= (sts_q == STS_ISSUED) ? cz_q : '0;
					out_q.nearest_index <= (sts_q == STS_ISSUED || sts_q == STS_ENDED) ?
						10'(best_q) : '0;
					out_q.target_index  <= (sts_q == STS_ISSUED || sts_q == STS_ENDED) ?
						11'(tgt_q) : '0;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LPF_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(PATH_DEPTH), "path length past depth")
	`LPF_ASSERT(a_empty_last, len_q == '0 |-> last_q == '0, "nearest index kept on empty path")
	`LPF_ASSERT(a_write_quiet, mem_we |-> !pipe_busy, "path write during a scan")
	`LPF_ASSERT(a_out_from_fin, $rose(out_valid) |-> $past(state_q == ST_FIN),
		"result raised outside the finish state")
endmodule
